// ----- design/accel_tilt_angle_atan2_macros.svh -----
// assertion helpers used by the checker file
`ifndef ACCEL_TILT_ANGLE_ATAN2_MACROS_SVH
`define ACCEL_TILT_ANGLE_ATAN2_MACROS_SVH

// concurrent assertion on i_clk, masked while reset is held
`define TILT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// concurrent assertion on i_clk that also covers reset cycles
`define TILT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/tilt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tilt_pkg;

    // port widths
    localparam int ACC_W     = 16;
    localparam int OFF_W     = 9;
    localparam int OUT_W     = 15;
    localparam int CFG_IDX_W = 2;

    // internal formats: angles are signed degrees with 16 fraction bits
    localparam int ANG_FRAC = 16;
    localparam int ANG_W    = 26;
    localparam int VEC_W    = 36;
    localparam int TAB_W    = 22;
    localparam int FIN_W    = 27;

    typedef logic signed [ACC_W-1:0] t_accel;
    typedef logic signed [ANG_W-1:0] t_angle;
    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic [OFF_W-1:0]        t_offset;
    typedef logic [OUT_W-1:0]        t_out_angle;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 2'd0,
        REG_OFFSET_Y = 2'd1
    } t_cfg_reg;

    localparam t_offset OFF_RESET = 9'd270;
    localparam t_offset DEG_360   = 9'd360;

    localparam t_angle ANG_90   = t_angle'(90 * 65536);
    localparam t_angle ANG_M90  = t_angle'(-90 * 65536);
    localparam t_angle ANG_180  = t_angle'(180 * 65536);
    localparam t_angle ANG_M180 = t_angle'(-180 * 65536);

    localparam logic [FIN_W-1:0] FULL_FIN = FIN_W'(360 * 65536);

    // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
    function automatic logic [TAB_W-1:0] atan_tab(input int unsigned idx);
        logic [TAB_W-1:0] v;
        case (idx)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/accel_tilt_angle_atan2.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tilt angles from one accelerometer sample per transaction: angle_x is
// atan2(z, y) and angle_y is atan2(z, x), each taken into [0, 360) degrees,
// shifted by its whole-degree offset register modulo 360 and rounded to
// 1/2^ANGLE_FRAC_BITS degree. Two CORDIC lanes run side by side, each an
// entry register and CORDIC_STAGES pipelined rotation stages, followed by a
// three-stage finishing pipe per lane; a new sample is taken every cycle
// while the output side keeps up. A stall at the output freezes the whole
// pipe. Offsets are reduced modulo 360 when written, reset to 270 and are
// meant to be written while the pipe is empty.
module accel_tilt_angle_atan2 #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tilt_pkg::t_accel                   i_accel_x,
    input  tilt_pkg::t_accel                   i_accel_y,
    input  tilt_pkg::t_accel                   i_accel_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tilt_pkg::t_out_angle               o_angle_x,
    output tilt_pkg::t_out_angle               o_angle_y,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tilt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  tilt_pkg::t_offset                  i_cfg_data
);
    import tilt_pkg::*;

    localparam int DEPTH = CORDIC_STAGES + 4;

    logic [DEPTH-1:0] r_vld, n_vld;
    logic             w_en;
    t_offset          r_off_x, r_off_y, n_off;
    t_angle           w_ang_x, w_ang_y;

    // pipe advances whenever the output register is free or being taken
    assign w_en        = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[DEPTH-1];
    assign n_vld       = {r_vld[DEPTH-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // offset registers, stored already reduced modulo 360
    assign o_cfg_ready = 1'b1;
    assign n_off       = (i_cfg_data >= DEG_360) ? i_cfg_data - DEG_360 : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= OFF_RESET;
            r_off_y <= OFF_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_OFFSET_X: r_off_x <= n_off;
                REG_OFFSET_Y: r_off_y <= n_off;
                default: ;
            endcase
        end
    end

    // lane for the angle about x: atan2(z, y)
    tilt_lane #(.STAGES(CORDIC_STAGES)) u_lane_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (i_accel_z),
        .i_den   (i_accel_y),
        .o_angle (w_ang_x)
    );

    // lane for the angle about y: atan2(z, x)
    tilt_lane #(.STAGES(CORDIC_STAGES)) u_lane_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (i_accel_z),
        .i_den   (i_accel_x),
        .o_angle (w_ang_y)
    );

    // merge: offset, wrap and rounding into the output register
    tilt_finish #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_fin_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_angle  (w_ang_x),
        .i_offset (r_off_x),
        .o_angle  (o_angle_x)
    );

    tilt_finish #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_fin_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_angle  (w_ang_y),
        .i_offset (r_off_y),
        .o_angle  (o_angle_y)
    );

endmodule

`default_nettype wire

// ----- design/tilt_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tilt_lane #(
    parameter int STAGES = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  tilt_pkg::t_accel i_num,
    input  tilt_pkg::t_accel i_den,
    output tilt_pkg::t_angle o_angle
);
    import tilt_pkg::*;

    t_vec   r_x    [0:STAGES-1];
    t_vec   r_y    [0:STAGES-1];
    t_angle r_z    [0:STAGES];
    logic   r_spec [0:STAGES-1];

    t_vec   n_x    [0:STAGES-1];
    t_vec   n_y    [0:STAGES-1];
    t_angle n_z    [0:STAGES];
    logic   n_spec [0:STAGES-1];

    // entry: axis cases, half-turn for a negative denominator,
    // then the vectoring micro-rotations, one per pipeline stage
    always_comb begin
        n_x[0]    = t_vec'(i_den) <<< ANG_FRAC;
        n_y[0]    = t_vec'(i_num) <<< ANG_FRAC;
        n_z[0]    = '0;
        n_spec[0] = 1'b0;
        if (i_num == '0) begin
            n_spec[0] = 1'b1;
            n_z[0]    = i_den[ACC_W-1] ? ANG_180 : t_angle'(0);
        end else if (i_den == '0) begin
            n_spec[0] = 1'b1;
            n_z[0]    = i_num[ACC_W-1] ? ANG_M90 : ANG_90;
        end else if (i_den[ACC_W-1]) begin
            n_x[0] = -n_x[0];
            n_y[0] = -n_y[0];
            n_z[0] = i_num[ACC_W-1] ? ANG_M180 : ANG_180;
        end

        for (int i = 0; i < STAGES; i++) begin
            if (!r_y[i][VEC_W-1]) begin
                n_z[i+1] = r_spec[i] ? r_z[i] : r_z[i] + t_angle'(atan_tab(i));
            end else begin
                n_z[i+1] = r_spec[i] ? r_z[i] : r_z[i] - t_angle'(atan_tab(i));
            end
            if (i + 1 < STAGES) begin
                if (!r_y[i][VEC_W-1]) begin
                    n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                    n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                end else begin
                    n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                    n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                end
                n_spec[i+1] = r_spec[i];
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_z[k] <= n_z[k];
            end
            for (int k = 0; k < STAGES; k++) begin
                r_x[k]    <= n_x[k];
                r_y[k]    <= n_y[k];
                r_spec[k] <= n_spec[k];
            end
        end
    end

    assign o_angle = r_z[STAGES];

endmodule

`default_nettype wire

// ----- design/tilt_finish.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tilt_finish #(
    parameter int FRAC_BITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  tilt_pkg::t_angle     i_angle,
    input  tilt_pkg::t_offset    i_offset,
    output tilt_pkg::t_out_angle o_angle
);
    import tilt_pkg::*;

    localparam int RND_SHIFT = ANG_FRAC - FRAC_BITS;
    localparam int RND_W     = FIN_W + 1;
    localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (RND_SHIFT - 1);
    localparam logic [RND_W-1:0] OUT_FULL = RND_W'(360) << FRAC_BITS;

    logic [FIN_W-1:0] r_pos, n_pos;
    logic [FIN_W-1:0] r_sum, n_sum;
    logic [FIN_W-1:0] w_raw;
    logic [RND_W-1:0] w_rnd;
    t_out_angle       r_out, n_out;

    // move negative angles into one turn
    always_comb begin
        n_pos = FIN_W'(i_angle) + (i_angle[ANG_W-1] ? FULL_FIN : FIN_W'(0));
    end

    // add the offset, wrap once
    always_comb begin
        w_raw = r_pos + (FIN_W'(i_offset) << ANG_FRAC);
        n_sum = (w_raw >= FULL_FIN) ? w_raw - FULL_FIN : w_raw;
    end

    // round half up, wrap a full turn to zero
    always_comb begin
        w_rnd = ({1'b0, r_sum} + RND_HALF) >> RND_SHIFT;
        if (w_rnd >= OUT_FULL) begin
            w_rnd = w_rnd - OUT_FULL;
        end
        n_out = w_rnd[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_out <= n_out;
        end
    end

    assign o_angle = r_out;

endmodule

`default_nettype wire

// ----- design/tilt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "accel_tilt_angle_atan2_macros.svh"

module tilt_checker #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input tilt_pkg::t_out_angle o_angle_x,
    input tilt_pkg::t_out_angle o_angle_y
);
    localparam int OUT_LIMIT = 360 << ANGLE_FRAC_BITS;

    // reset empties the output register
    `TILT_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // an empty output register never blocks the input side
    `TILT_ASSERT(a_ready_when_empty, !o_out_valid |-> o_in_ready, "input stalled with empty output")

    // a stalled result holds
    `TILT_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_angle_x) && $stable(o_angle_y), "stalled result changed")

    // angles stay below one full turn when the format holds it
    `TILT_ASSERT(a_angle_range, o_out_valid |-> (ANGLE_FRAC_BITS > 6 || (int'(o_angle_x) < OUT_LIMIT && int'(o_angle_y) < OUT_LIMIT)), "angle at or above a full turn")

endmodule

bind accel_tilt_angle_atan2 tilt_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_tilt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_angle_x   (o_angle_x),
    .o_angle_y   (o_angle_y)
);

`default_nettype wire

// ----- tb/accel_tilt_angle_atan2_test.sv -----
`timescale 1ns / 1ps

module accel_tilt_angle_atan2_test;
    import tilt_pkg::*;

    localparam int N_STAGES    = 16;
    localparam int FRAC_BITS   = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 100;
    localparam longint DEG     = 65536;
    localparam longint FULL    = 360 * DEG;

    // index that decodes to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

    // atan(2^-i) in degrees, 16 fraction bits
    localparam longint ATAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        t_out_angle ax;
        t_out_angle ay;
    } t_tilt_pair;

    typedef struct packed {
        t_accel     x;
        t_accel     y;
        t_accel     z;
        logic       typed;
        t_tilt_pair angles;
    } t_sample_row;

    // directed samples; typed rows assume the reset offsets of 270 degrees
    localparam int N_DIRECTED = 19;
    localparam t_sample_row DIRECTED [N_DIRECTED] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{15'd17280, 15'd17280}},
        '{16'sd5,      -16'sd7,     16'sd0,      1'b1, '{15'd5760,  15'd17280}},
        '{16'sd0,      16'sd0,      16'sd100,    1'b1, '{15'd0,     15'd0}},
        '{16'sd0,      16'sd0,      -16'sd100,   1'b1, '{15'd11520, 15'd11520}},
        '{16'sd32767,  -16'sd32768, 16'sd0,      1'b1, '{15'd5760,  15'd17280}},
        '{-16'sd32768, 16'sd32767,  16'sd0,      1'b1, '{15'd17280, 15'd5760}},
        '{16'sd0,      16'sd0,      16'sd32767,  1'b1, '{15'd0,     15'd0}},
        '{16'sd0,      16'sd0,      -16'sd32768, 1'b1, '{15'd11520, 15'd11520}},
        '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '{15'd0, 15'd0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{15'd0, 15'd0}},
        '{-16'sd32768, 16'sd32767,  -16'sd32768, 1'b0, '{15'd0, 15'd0}},
        '{16'sd32767,  -16'sd32768, 16'sd32767,  1'b0, '{15'd0, 15'd0}},
        '{16'sd1,      16'sd1,      16'sd1,      1'b0, '{15'd0, 15'd0}},
        '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, '{15'd0, 15'd0}},
        '{-16'sd3,     -16'sd3,     16'sd5,      1'b0, '{15'd0, 15'd0}},
        '{-16'sd3,     -16'sd3,     -16'sd5,     1'b0, '{15'd0, 15'd0}},
        '{16'sd1,      16'sd32767,  -16'sd1,     1'b0, '{15'd0, 15'd0}},
        '{-16'sd32768, -16'sd1,     16'sd32767,  1'b0, '{15'd0, 15'd0}},
        '{16'sd12345,  -16'sd23456, -16'sd345,   1'b0, '{15'd0, 15'd0}}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_accel               i_accel_x;
    t_accel               i_accel_y;
    t_accel               i_accel_z;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_angle           o_angle_x;
    t_out_angle           o_angle_y;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_offset              i_cfg_data;

    // predictor state and scoreboard
    t_offset    offset_x_copy = OFF_RESET;
    t_offset    offset_y_copy = OFF_RESET;
    t_tilt_pair pending_angles [$];
    logic       sample_typed;
    t_tilt_pair sample_angles;
    bit         steady;
    int         mismatches;
    int         cycle_count;

    accel_tilt_angle_atan2 #(
        .CORDIC_STAGES  (N_STAGES),
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_angle_x  (o_angle_x),
        .o_angle_y  (o_angle_y),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // vectoring cordic, signed degrees with 16 fraction bits
    function automatic longint cordic_atan2(input longint num, input longint den);
        longint vx, vy, acc, base, sx, sy;
        if (num == 0) return (den < 0) ? 180 * DEG : 0;
        if (den == 0) return (num > 0) ? 90 * DEG : -90 * DEG;
        vx   = den * DEG;
        vy   = num * DEG;
        base = 0;
        acc  = 0;
        // left half plane: turn by 180 degrees first
        if (den < 0) begin
            vx   = -vx;
            vy   = -vy;
            base = (num >= 0) ? 180 * DEG : -180 * DEG;
        end
        for (int i = 0; i < N_STAGES && i < 24; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + ATAN_DEG[i];
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - ATAN_DEG[i];
            end
        end
        return base + acc;
    endfunction

    // fold into [0, 360), add offset modulo 360, round half up
    function automatic t_out_angle offset_and_round(input longint ang, input t_offset off_reg);
        longint off, r;
        off = off_reg;
        if (off >= 360) off = off - 360;
        if (ang < 0) ang = ang + FULL;
        ang = ang + off * DEG;
        if (ang >= FULL) ang = ang - FULL;
        r = (ang + (longint'(1) << (15 - FRAC_BITS))) >>> (16 - FRAC_BITS);
        if (r >= (longint'(360) << FRAC_BITS)) r = r - (longint'(360) << FRAC_BITS);
        return t_out_angle'(r);
    endfunction

    function automatic t_tilt_pair predict_tilt(input t_accel ax, input t_accel ay,
                                                input t_accel az);
        t_tilt_pair p;
        p.ax = offset_and_round(cordic_atan2(longint'(az), longint'(ay)), offset_x_copy);
        p.ay = offset_and_round(cordic_atan2(longint'(az), longint'(ax)), offset_y_copy);
        return p;
    endfunction

    function automatic bit gap_roll();
        return !steady && ($urandom_range(0, 99) < 36);
    endfunction

    // small values, zeros and extremes show up often
    function automatic t_accel rand_accel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return t_accel'(int'($urandom_range(0, 8)) - 4);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return t_accel'($urandom());
        endcase
    endfunction

    task automatic note_mismatch(input string what, input int exp_v, input int act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
    endtask

    // watchdog and scoreboard, sampled at the rising edge
    always @(posedge i_clk) begin
        t_tilt_pair want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("accel_tilt_angle_atan2 test failed");
            $finish;
        end
        if (!i_rst_n) begin
            offset_x_copy = OFF_RESET;
            offset_y_copy = OFF_RESET;
        end else begin
            // register write transaction
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_OFFSET_X: offset_x_copy = i_cfg_data;
                    REG_OFFSET_Y: offset_y_copy = i_cfg_data;
                    default: ;
                endcase
            end
            // sample transaction
            if (i_in_valid && o_in_ready) begin
                if (sample_typed)
                    pending_angles.push_back(sample_angles);
                else
                    pending_angles.push_back(predict_tilt(i_accel_x, i_accel_y, i_accel_z));
            end
            // result transaction
            if (o_out_valid && i_out_ready) begin
                if (pending_angles.size() == 0) begin
                    note_mismatch("result with nothing pending", -1, int'(o_angle_x));
                end else begin
                    want = pending_angles.pop_front();
                    if (o_angle_x !== want.ax)
                        note_mismatch("angle_x", int'(want.ax), int'(o_angle_x));
                    if (o_angle_y !== want.ay)
                        note_mismatch("angle_y", int'(want.ay), int'(o_angle_y));
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = !gap_roll();
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_sample(input t_accel ax, input t_accel ay, input t_accel az,
                               input logic typed, input t_tilt_pair angles);
        while (gap_roll()) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_accel_x     = ax;
        i_accel_y     = ay;
        i_accel_z     = az;
        sample_typed  = typed;
        sample_angles = angles;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_offset val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop sending and wait for every pending result
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_angles.size() != 0) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        t_offset phase_x [6];
        t_offset phase_y [6];
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_accel_x     = '0;
        i_accel_y     = '0;
        i_accel_z     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_OFFSET_X;
        i_cfg_data    = '0;
        sample_typed  = 1'b0;
        sample_angles = '0;
        steady        = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;

        // offset settings per phase: extremes, out of range, random
        phase_x = '{9'd0, 9'd359, 9'd360, 9'd1, t_offset'($urandom()), t_offset'($urandom())};
        phase_y = '{9'd0, 9'd359, 9'd511, 9'd180, t_offset'($urandom()), t_offset'($urandom())};

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed samples at reset offsets
        for (int k = 0; k < N_DIRECTED; k++)
            send_sample(DIRECTED[k].x, DIRECTED[k].y, DIRECTED[k].z,
                        DIRECTED[k].typed, DIRECTED[k].angles);
        drain();

        // random phases, one offset setting each
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_OFFSET_X, phase_x[p]);
            write_reg(REG_OFFSET_Y, phase_y[p]);
            if (p == 2) write_reg(REG_UNUSED, 9'h1ff);
            steady = (p == 3);
            for (int n = 0; n < N_RANDOM; n++)
                send_sample(rand_accel(), rand_accel(), rand_accel(), 1'b0, '0);
            drain();
            steady = 1'b0;
        end

        repeat (N_STAGES + 8) @(negedge i_clk);
        if (mismatches == 0 && pending_angles.size() == 0)
            $display("accel_tilt_angle_atan2 test passed");
        else
            $display("accel_tilt_angle_atan2 test failed");
        $finish;
    end

endmodule
